/* src/kefuf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kefuf_pkg
// Shared types and constants for the Kruskal edge filter on a union-find store.
// ----------------------------------------------------------------------------
package kefuf_pkg;

	// store geometry
	localparam int MAX_CELLS = 4096;
	localparam int CELL_W    = $clog2(MAX_CELLS);
	localparam int COUNT_W   = 13;
	localparam int RANK_W    = 4;

	localparam logic [RANK_W-1:0]  RANK_MAX  = '1;
	localparam logic [COUNT_W-1:0] CELLS_TOP = COUNT_W'(MAX_CELLS);

	// opcodes
	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_EDGE  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CONNECTED = 2'd1;
	localparam logic [1:0] ST_INVALID   = 2'd2;

	// one store entry: parent link and rank of the set rooted here
	typedef struct packed {
		logic [CELL_W-1:0] parent;
		logic [RANK_W-1:0] rank;
	} node_t;

	// sequencer states
	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_FIND_A = 5'b00100,
		S_FIND_B = 5'b01000,
		S_RANK   = 5'b10000
	} state_t;

endpackage

/* src/kefuf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kefuf_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module kefuf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write first in array, read returns old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* src/kruskal_edge_filter_union_find.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_edge_filter_union_find
// Kruskal spanning-tree edge filter: union-find with union by rank in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item is taken at a clock edge with start high and busy
//   low. opcode 0 clears all sets; opcode 1 offers the edge cell_a - cell_b.
//   Result channel: done is high for exactly one cycle with status and
//   components_left; the receiver cannot hold it off, so it is never delayed.
//   Config: cfg_we writes cfg_data into cell_count (cells in use); write only
//   while busy is low. A new count bounds edges at once, the component count
//   is reloaded only by the next clear.
// Timing:
//   Invalid edge: result in the cycle after the transfer.
//   Valid edge: one RAM read per tree level on each root walk, root A in
//   S_FIND_A then root B in S_FIND_B, then the result. busy drops with
//   the result, or after the S_RANK state when a rank bump is needed. Depth
//   is at most 12 with union by rank on 4096 cells.
//   Clear: a sweep that writes each of the 4096 RAM entries, result after the last entry.
// Reset:
//   arst_n starts the same sweep with no result; busy is high
//   until it ends, then the component count is 4096.
// ----------------------------------------------------------------------------
module kruskal_edge_filter_union_find
	import kefuf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  logic [11:0]        cell_a,
	input  logic [11:0]        cell_b,
	input  logic               cfg_we,
	input  logic [12:0]        cfg_data,
	output logic               done,
	output logic [1:0]         status,
	output logic [12:0]        components_left
);

	state_t             state_q;
	logic [CELL_W-1:0]  clr_idx_q;
	logic               clr_report_q;
	logic [COUNT_W-1:0] cell_count_q;
	logic [COUNT_W-1:0] count_q;
	logic [CELL_W-1:0]  x_q;
	logic [CELL_W-1:0]  b_q;
	logic [CELL_W-1:0]  ra_q;
	logic [RANK_W-1:0]  rank_a_q;
	logic               done_q;
	logic [1:0]         status_q;

	logic               ram_we;
	logic [CELL_W-1:0]  ram_addr;
	node_t              ram_wdata;
	node_t              rd;
	logic [COUNT_W-1:0] n_eff;
	logic               edge_bad;
	logic               at_root;
	logic               accept;
	logic [COUNT_W-1:0] count_dec;
	logic [RANK_W-1:0]  rank_inc;

	kefuf_ram #(
		.WIDTH($bits(node_t)),
		.DEPTH(MAX_CELLS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (rd)
	);

	// cells in use, saturated to 1..MAX_CELLS
	always_comb begin
		if (cell_count_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (cell_count_q > CELLS_TOP) begin
			n_eff = CELLS_TOP;
		end else begin
			n_eff = cell_count_q;
		end
	end

	assign accept    = start && !busy;
	assign edge_bad  = (COUNT_W'(cell_a) >= n_eff) || (COUNT_W'(cell_b) >= n_eff) ||
	                   (cell_a == cell_b);
	assign at_root   = (rd.parent == x_q);
	assign count_dec = (count_q != '0) ? count_q - COUNT_W'(1) : count_q;
	assign rank_inc  = (rank_a_q != RANK_MAX) ? rank_a_q + RANK_W'(1) : rank_a_q;

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = x_q;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_idx_q;
				ram_wdata = '{parent: clr_idx_q, rank: '0};
			end
			S_IDLE: begin
				ram_addr = cell_a;
			end
			S_FIND_A: begin
				ram_addr = at_root ? b_q : rd.parent;
			end
			S_FIND_B: begin
				if (!at_root) begin
					ram_addr = rd.parent;
				end else if (x_q != ra_q) begin
					// link the lower-ranked root under the other
					ram_we = 1'b1;
					if (rank_a_q < rd.rank) begin
						ram_addr  = ra_q;
						ram_wdata = '{parent: x_q, rank: rank_a_q};
					end else begin
						ram_addr  = x_q;
						ram_wdata = '{parent: ra_q, rank: rd.rank};
					end
				end
			end
			S_RANK: begin
				ram_we    = 1'b1;
				ram_addr  = ra_q;
				ram_wdata = '{parent: ra_q, rank: rank_inc};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= CELLS_TOP;
		end else if (cfg_we) begin
			cell_count_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			clr_report_q <= 1'b0;
			count_q      <= CELLS_TOP;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			x_q          <= '0;
			b_q          <= '0;
			ra_q         <= '0;
			rank_a_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + CELL_W'(1);
					if (clr_idx_q == CELL_W'(MAX_CELLS - 1)) begin
						state_q <= S_IDLE;
						count_q <= n_eff;
						if (clr_report_q) begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
						end
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (opcode == OP_CLEAR) begin
							state_q      <= S_CLEAR;
							clr_idx_q    <= '0;
							clr_report_q <= 1'b1;
						end else if (edge_bad) begin
							done_q   <= 1'b1;
							status_q <= ST_INVALID;
						end else begin
							state_q <= S_FIND_A;
							x_q     <= cell_a;
							b_q     <= cell_b;
						end
					end
				end
				S_FIND_A: begin
					if (at_root) begin
						ra_q     <= x_q;
						rank_a_q <= rd.rank;
						x_q      <= b_q;
						state_q  <= S_FIND_B;
					end else begin
						x_q <= rd.parent;
					end
				end
				S_FIND_B: begin
					if (!at_root) begin
						x_q <= rd.parent;
					end else if (x_q == ra_q) begin
						done_q   <= 1'b1;
						status_q <= ST_CONNECTED;
						state_q  <= S_IDLE;
					end else begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						count_q  <= count_dec;
						state_q  <= (rank_a_q == rd.rank) ? S_RANK : S_IDLE;
					end
				end
				S_RANK: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign components_left = count_q;

	// checks
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ram_we)
		else $error("store written while idle");

	a_invalid_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == OP_EDGE) && (cell_a == cell_b)) |=>
		(done && (status == ST_INVALID)))
		else $error("self-loop edge not flagged invalid next cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (components_left <= CELLS_TOP) && (status != 2'd3))
		else $error("result out of range");

	a_no_done_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == OP_CLEAR)) |=> !done)
		else $error("clear reported before its sweep");

endmodule
